[hdl/rcss_pkg.sv]
// ----------------------------------------------------------------------------
// rcss_pkg
// Shared types and constants for the robot command and servo sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package rcss_pkg;

   localparam int AngleWidth  = 11;
   localparam int PulseWidth  = 12;
   localparam int StepWidth   = 7;
   localparam int SettleWidth = 4;
   localparam int CsrIdxWidth = 3;
   localparam int CsrDatWidth = 11;

   // Command byte codes.
   localparam logic [7:0] CmdNone   = 8'd0;
   localparam logic [7:0] CmdPickup = 8'd253;
   localparam logic [7:0] CmdDrop   = 8'd254;
   localparam logic [7:0] CmdStop   = 8'd255;

   // Register reset values.
   localparam logic [StepWidth-1:0]   RampStepRst   = 7'd10;
   localparam logic [AngleWidth-1:0]  LiftLowRst    = 11'd1200;
   localparam logic [AngleWidth-1:0]  LiftHighRst   = 11'd1800;
   localparam logic [AngleWidth-1:0]  GripOpenRst   = 11'd900;
   localparam logic [AngleWidth-1:0]  GripClosedRst = 11'd0;
   localparam logic [AngleWidth-1:0]  NeutralRst    = 11'd1500;
   localparam logic [SettleWidth-1:0] SettleRst     = 4'd5;

   // Servo positions after reset.
   localparam logic [AngleWidth-1:0]  LiftPosRst    = 11'd1800;
   localparam logic [AngleWidth-1:0]  GripPosRst    = 11'd900;

   typedef enum logic [CsrIdxWidth-1:0] {
      REG_RAMP_STEP    = 3'd0,
      REG_LIFT_LOW     = 3'd1,
      REG_LIFT_HIGH    = 3'd2,
      REG_GRIP_OPEN    = 3'd3,
      REG_GRIP_CLOSED  = 3'd4,
      REG_NEUTRAL      = 3'd5,
      REG_SETTLE_TICKS = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_PICKUP = 2'd1,
      OP_DROP   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_LOWER  = 3'd1,
      PH_GRIP   = 3'd2,
      PH_SETTLE = 3'd3,
      PH_RAISE  = 3'd4
   } phase_type;

   typedef enum logic {
      ITEM_BYTE = 1'b0,
      ITEM_TICK = 1'b1
   } item_kind_type;

   typedef struct packed {
      logic [StepWidth-1:0]   ramp_step;
      logic [AngleWidth-1:0]  lift_low_angle;
      logic [AngleWidth-1:0]  lift_high_angle;
      logic [AngleWidth-1:0]  grip_open_angle;
      logic [AngleWidth-1:0]  grip_closed_angle;
      logic [AngleWidth-1:0]  neutral_pulse_us;
      logic [SettleWidth-1:0] settle_ticks;
   } cfg_type;

   // Gripper state as it stands after the transaction being processed.
   typedef struct packed {
      logic [AngleWidth-1:0] lift_angle;
      logic [AngleWidth-1:0] grip_angle;
      logic                  busy;
   } grip_status_type;

   // One accepted input transaction, handed to the processing units.
   typedef struct packed {
      logic       fire;
      logic       tick;
      logic [7:0] rx_byte;
   } item_type;

endpackage

`default_nettype wire

[hdl/rcss_csr.sv]
// ----------------------------------------------------------------------------
// rcss_csr
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module rcss_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                wr_en,
   input  wire logic [rcss_pkg::CsrIdxWidth-1:0]    wr_index,
   input  wire logic [rcss_pkg::CsrDatWidth-1:0]    wr_data,
   output rcss_pkg::cfg_type                        cfg
);

   rcss_pkg::cfg_type cfg_ff;
   rcss_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            rcss_pkg::REG_RAMP_STEP:    cfg_in.ramp_step = wr_data[rcss_pkg::StepWidth-1:0];
            rcss_pkg::REG_LIFT_LOW:     cfg_in.lift_low_angle = wr_data;
            rcss_pkg::REG_LIFT_HIGH:    cfg_in.lift_high_angle = wr_data;
            rcss_pkg::REG_GRIP_OPEN:    cfg_in.grip_open_angle = wr_data;
            rcss_pkg::REG_GRIP_CLOSED:  cfg_in.grip_closed_angle = wr_data;
            rcss_pkg::REG_NEUTRAL:      cfg_in.neutral_pulse_us = wr_data;
            rcss_pkg::REG_SETTLE_TICKS: begin
               cfg_in.settle_ticks = wr_data[rcss_pkg::SettleWidth-1:0];
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ramp_step         <= rcss_pkg::RampStepRst;
         cfg_ff.lift_low_angle    <= rcss_pkg::LiftLowRst;
         cfg_ff.lift_high_angle   <= rcss_pkg::LiftHighRst;
         cfg_ff.grip_open_angle   <= rcss_pkg::GripOpenRst;
         cfg_ff.grip_closed_angle <= rcss_pkg::GripClosedRst;
         cfg_ff.neutral_pulse_us  <= rcss_pkg::NeutralRst;
         cfg_ff.settle_ticks      <= rcss_pkg::SettleRst;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[hdl/rcss_drive.sv]
// ----------------------------------------------------------------------------
// rcss_drive
// Wheel speed registers, speed command decode and wheel pulse widths.
// ----------------------------------------------------------------------------
`default_nettype none

module rcss_drive (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire rcss_pkg::item_type                 item,
   input  wire logic [rcss_pkg::AngleWidth-1:0]    neutral_pulse_us,
   output logic [rcss_pkg::PulseWidth-1:0]         left_pulse_us,
   output logic [rcss_pkg::PulseWidth-1:0]         right_pulse_us
);

   logic signed [7:0] left_ff, left_in;
   logic signed [7:0] right_ff, right_in;
   logic        [6:0] mag;
   logic signed [7:0] speed;

   // Neutral plus or minus twice the speed, floored at zero; zero speed gives no pulse.
   function automatic logic [rcss_pkg::PulseWidth-1:0] pulse_width(
      input logic signed [7:0]                 spd,
      input logic                              plus,
      input logic [rcss_pkg::AngleWidth-1:0]   neutral
   );
      logic signed [12:0] dbl;
      logic signed [12:0] sum;
      dbl = {{4{spd[7]}}, spd, 1'b0};
      sum = plus ? ($signed({2'b00, neutral}) + dbl) : ($signed({2'b00, neutral}) - dbl);
      if (spd == 8'sd0) begin
         return '0;
      end else if (sum[12]) begin
         return '0;
      end else begin
         return sum[rcss_pkg::PulseWidth-1:0];
      end
   endfunction

   always_comb begin
      mag      = {item.rx_byte[7:2], 1'b0};
      speed    = item.rx_byte[1] ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
      left_in  = left_ff;
      right_in = right_ff;
      if (item.fire && !item.tick) begin
         if (item.rx_byte == rcss_pkg::CmdStop) begin
            left_in  = '0;
            right_in = '0;
         end else if (item.rx_byte != rcss_pkg::CmdPickup
                      && item.rx_byte != rcss_pkg::CmdDrop
                      && item.rx_byte != rcss_pkg::CmdNone) begin
            if (item.rx_byte[0]) begin
               right_in = speed;
            end else begin
               left_in = speed;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff  <= '0;
         right_ff <= '0;
      end else begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   // Widths reflect the speeds after the current transaction.
   assign left_pulse_us  = pulse_width(left_in, 1'b1, neutral_pulse_us);
   assign right_pulse_us = pulse_width(right_in, 1'b0, neutral_pulse_us);

endmodule

`default_nettype wire

[hdl/rcss_grip.sv]
// ----------------------------------------------------------------------------
// rcss_grip
// Gripper sequencer: pickup and drop phases with ramped lift and grip servos.
// ----------------------------------------------------------------------------
`default_nettype none

module rcss_grip (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rcss_pkg::item_type   item,
   input  wire rcss_pkg::cfg_type    cfg,
   output rcss_pkg::grip_status_type status
);

   rcss_pkg::phase_type                   phase_ff, phase_in;
   rcss_pkg::op_type                      op_ff, op_in;
   logic [rcss_pkg::AngleWidth-1:0]       lift_ff, lift_in;
   logic [rcss_pkg::AngleWidth-1:0]       grip_ff, grip_in;
   logic [rcss_pkg::SettleWidth-1:0]      cnt_ff, cnt_in;

   rcss_pkg::phase_type                   act;
   logic [rcss_pkg::SettleWidth-1:0]      cnt_eff;
   logic [rcss_pkg::AngleWidth-1:0]       grip_tgt;
   logic [rcss_pkg::AngleWidth-1:0]       ramp_pos;
   logic [rcss_pkg::AngleWidth-1:0]       ramp_tgt;
   logic [rcss_pkg::AngleWidth-1:0]       ramp_new;
   logic [rcss_pkg::StepWidth-1:0]        step;

   // One ramp step toward the target, landing on it rather than passing it.
   function automatic logic [rcss_pkg::AngleWidth-1:0] ramp(
      input logic [rcss_pkg::AngleWidth-1:0] pos,
      input logic [rcss_pkg::AngleWidth-1:0] tgt,
      input logic [rcss_pkg::StepWidth-1:0]  st
   );
      logic [rcss_pkg::AngleWidth-1:0] diff;
      logic [rcss_pkg::AngleWidth-1:0] st_ext;
      st_ext = {{(rcss_pkg::AngleWidth-rcss_pkg::StepWidth){1'b0}}, st};
      diff   = (pos < tgt) ? (tgt - pos) : (pos - tgt);
      if (diff <= st_ext) begin
         return tgt;
      end else if (pos < tgt) begin
         return pos + st_ext;
      end else begin
         return pos - st_ext;
      end
   endfunction

   always_comb begin
      phase_in = phase_ff;
      op_in    = op_ff;
      lift_in  = lift_ff;
      grip_in  = grip_ff;
      cnt_in   = cnt_ff;

      step     = (cfg.ramp_step == '0) ? {{(rcss_pkg::StepWidth-1){1'b0}}, 1'b1}
                                        : cfg.ramp_step;
      grip_tgt = (op_ff == rcss_pkg::OP_PICKUP) ? cfg.grip_closed_angle
                                                : cfg.grip_open_angle;

      // A phase whose target is already met is passed within the same tick,
      // so find the first phase that still has work to do.
      act     = phase_ff;
      cnt_eff = cnt_ff;
      if (act == rcss_pkg::PH_LOWER && lift_ff == cfg.lift_low_angle) begin
         act = rcss_pkg::PH_GRIP;
      end
      if (act == rcss_pkg::PH_GRIP && grip_ff == grip_tgt) begin
         if (op_ff == rcss_pkg::OP_PICKUP) begin
            act     = rcss_pkg::PH_SETTLE;
            cnt_eff = '0;
         end else begin
            act = rcss_pkg::PH_RAISE;
         end
      end
      if (act == rcss_pkg::PH_SETTLE && cnt_eff >= cfg.settle_ticks) begin
         act = rcss_pkg::PH_RAISE;
      end
      if (act == rcss_pkg::PH_RAISE && lift_ff == cfg.lift_high_angle) begin
         act = rcss_pkg::PH_IDLE;
      end

      ramp_pos = (act == rcss_pkg::PH_GRIP) ? grip_ff : lift_ff;
      case (act)
         rcss_pkg::PH_GRIP:  ramp_tgt = grip_tgt;
         rcss_pkg::PH_RAISE: ramp_tgt = cfg.lift_high_angle;
         default:            ramp_tgt = cfg.lift_low_angle;
      endcase
      ramp_new = ramp(ramp_pos, ramp_tgt, step);

      if (item.fire && item.tick) begin
         if (phase_ff != rcss_pkg::PH_IDLE) begin
            cnt_in = cnt_eff;
            case (act)
               rcss_pkg::PH_LOWER: begin
                  lift_in  = ramp_new;
                  phase_in = (ramp_new == ramp_tgt) ? rcss_pkg::PH_GRIP : rcss_pkg::PH_LOWER;
               end
               rcss_pkg::PH_GRIP: begin
                  grip_in  = ramp_new;
                  phase_in = rcss_pkg::PH_GRIP;
                  if (ramp_new == ramp_tgt) begin
                     if (op_ff == rcss_pkg::OP_PICKUP) begin
                        phase_in = rcss_pkg::PH_SETTLE;
                        cnt_in   = '0;
                     end else begin
                        phase_in = rcss_pkg::PH_RAISE;
                     end
                  end
               end
               rcss_pkg::PH_SETTLE: begin
                  cnt_in   = cnt_eff + 1'b1;
                  phase_in = (cnt_in >= cfg.settle_ticks) ? rcss_pkg::PH_RAISE
                                                          : rcss_pkg::PH_SETTLE;
               end
               rcss_pkg::PH_RAISE: begin
                  lift_in = ramp_new;
                  if (ramp_new == ramp_tgt) begin
                     phase_in = rcss_pkg::PH_IDLE;
                     op_in    = rcss_pkg::OP_NONE;
                  end
               end
               default: begin
                  phase_in = rcss_pkg::PH_IDLE;
                  op_in    = rcss_pkg::OP_NONE;
               end
            endcase
         end
      end else if (item.fire) begin
         if ((item.rx_byte == rcss_pkg::CmdPickup || item.rx_byte == rcss_pkg::CmdDrop)
             && phase_ff == rcss_pkg::PH_IDLE) begin
            op_in    = (item.rx_byte == rcss_pkg::CmdPickup) ? rcss_pkg::OP_PICKUP
                                                             : rcss_pkg::OP_DROP;
            phase_in = rcss_pkg::PH_LOWER;
            cnt_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= rcss_pkg::PH_IDLE;
         op_ff    <= rcss_pkg::OP_NONE;
         lift_ff  <= rcss_pkg::LiftPosRst;
         grip_ff  <= rcss_pkg::GripPosRst;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         lift_ff  <= lift_in;
         grip_ff  <= grip_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      status.lift_angle = lift_in;
      status.grip_angle = grip_in;
      status.busy       = (phase_in != rcss_pkg::PH_IDLE);
   end

endmodule

`default_nettype wire

[hdl/robot_command_servo_sequencer.sv]
// ----------------------------------------------------------------------------
// robot_command_servo_sequencer
// Decodes command bytes and millisecond ticks into wheel pulse widths and
// ramped lift and grip servo angles for a pickup and drop gripper.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_ready   req_item_kind, req_rx_byte
//   rsp      out        rsp_valid/rsp_ready   wheel pulses, servo angles, busy
//   csr      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// Each transaction is captured in an input register and processed when it
// moves on, where the state updates and the result register loads; one
// transaction is taken every cycle while rsp is not stalled. A stalled rsp
// stops the input register from draining, and req_ready then drops.
// Reset restores register defaults, stops both wheels and parks the gripper.
// ----------------------------------------------------------------------------
`default_nettype none

module robot_command_servo_sequencer (
   input  wire logic                                clock,
   input  wire logic                                reset,

   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_item_kind,
   input  wire logic [7:0]                          req_rx_byte,

   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [rcss_pkg::PulseWidth-1:0]          rsp_left_pulse_us,
   output logic [rcss_pkg::PulseWidth-1:0]          rsp_right_pulse_us,
   output logic [rcss_pkg::AngleWidth-1:0]          rsp_lift_angle,
   output logic [rcss_pkg::AngleWidth-1:0]          rsp_grip_angle,
   output logic                                     rsp_gripper_busy,

   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [rcss_pkg::CsrIdxWidth-1:0]    csr_index,
   input  wire logic [rcss_pkg::CsrDatWidth-1:0]    csr_wdata
);

   logic                             in_vld_ff, in_vld_in;
   logic                             in_kind_ff;
   logic [7:0]                       in_byte_ff;
   logic                             rsp_vld_ff, rsp_vld_in;
   logic [rcss_pkg::PulseWidth-1:0]  left_ff, right_ff;
   logic [rcss_pkg::AngleWidth-1:0]  lift_ff, grip_ff;
   logic                             busy_ff;
   logic                             adv;

   rcss_pkg::cfg_type                cfg;
   rcss_pkg::item_type               item;
   rcss_pkg::grip_status_type        grip_status;
   logic [rcss_pkg::PulseWidth-1:0]  left_pulse;
   logic [rcss_pkg::PulseWidth-1:0]  right_pulse;

   // The held transaction moves on when the result register is free or draining.
   assign adv        = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready  = !in_vld_ff || adv;
   assign in_vld_in  = (req_valid && req_ready) || (in_vld_ff && !adv);
   assign rsp_vld_in = adv || (rsp_vld_ff && !rsp_ready);
   assign csr_ready  = 1'b1;

   always_comb begin
      item.fire    = adv;
      item.tick    = (in_kind_ff == rcss_pkg::ITEM_TICK);
      item.rx_byte = in_byte_ff;
   end

   rcss_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   rcss_drive u_drive (
      .clock            (clock),
      .reset            (reset),
      .item             (item),
      .neutral_pulse_us (cfg.neutral_pulse_us),
      .left_pulse_us    (left_pulse),
      .right_pulse_us   (right_pulse)
   );

   rcss_grip u_grip (
      .clock  (clock),
      .reset  (reset),
      .item   (item),
      .cfg    (cfg),
      .status (grip_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_kind_ff <= req_item_kind;
         in_byte_ff <= req_rx_byte;
      end
      if (adv) begin
         left_ff  <= left_pulse;
         right_ff <= right_pulse;
         lift_ff  <= grip_status.lift_angle;
         grip_ff  <= grip_status.grip_angle;
         busy_ff  <= grip_status.busy;
      end
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_left_pulse_us  = left_ff;
   assign rsp_right_pulse_us = right_ff;
   assign rsp_lift_angle     = lift_ff;
   assign rsp_grip_angle     = grip_ff;
   assign rsp_gripper_busy   = busy_ff;

endmodule

`default_nettype wire

[tb/tb_robot_command_servo_sequencer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_robot_command_servo_sequencer
// Drives command bytes and millisecond ticks into the servo sequencer, keeps
// its own copy of the wheel speeds, gripper sequence and register set, and
// checks every result transaction field by field in arrival order. The run
// steps through several register settings, extremes among them, with random
// stalls on both channels, one long result stall and one drain pause.
// ----------------------------------------------------------------------------

module tb_robot_command_servo_sequencer;

   localparam int IdleLimit = 2000;
   localparam int LongStall = 300;
   localparam int DrainWait = 4;
   localparam logic [rcss_pkg::CsrIdxWidth-1:0] RegUnmapped = 3'd7;

   typedef struct {
      logic       kind;
      logic [7:0] rx;
   } servo_cmd_type;

   typedef struct packed {
      logic [rcss_pkg::PulseWidth-1:0] left_pulse;
      logic [rcss_pkg::PulseWidth-1:0] right_pulse;
      logic [rcss_pkg::AngleWidth-1:0] lift;
      logic [rcss_pkg::AngleWidth-1:0] grip;
      logic                            busy;
   } servo_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic                             req_item_kind = 1'b0;
   logic [7:0]                       req_rx_byte = 8'd0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [rcss_pkg::PulseWidth-1:0]  rsp_left_pulse_us;
   logic [rcss_pkg::PulseWidth-1:0]  rsp_right_pulse_us;
   logic [rcss_pkg::AngleWidth-1:0]  rsp_lift_angle;
   logic [rcss_pkg::AngleWidth-1:0]  rsp_grip_angle;
   logic                             rsp_gripper_busy;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [rcss_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [rcss_pkg::CsrDatWidth-1:0] csr_wdata = '0;

   // Predicted block state and register set.
   rcss_pkg::cfg_type    cfg_model;
   logic signed [7:0]    wheel_left;
   logic signed [7:0]    wheel_right;
   rcss_pkg::op_type     grip_op;
   rcss_pkg::phase_type  grip_phase;
   int                   lift_pos;
   int                   grip_pos;
   int                   settle_cnt;

   servo_cmd_type    pending_cmds[$];
   servo_report_type expected_reports[$];

   int mismatch_count = 0;
   int idle_cycles = 0;
   int send_gap = 0;
   int hold_left = 0;
   bit idle_on = 1'b1;
   bit rsp_stall_req = 1'b0;

   robot_command_servo_sequencer u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_item_kind      (req_item_kind),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_left_pulse_us  (rsp_left_pulse_us),
      .rsp_right_pulse_us (rsp_right_pulse_us),
      .rsp_lift_angle     (rsp_lift_angle),
      .rsp_grip_angle     (rsp_grip_angle),
      .rsp_gripper_busy   (rsp_gripper_busy),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always #1 clock = ~clock;

   // Moves a servo one ramp step toward its target, stopping at the target.
   function automatic bit step_servo(inout int pos, input int target);
      int st;
      st = (cfg_model.ramp_step == 0) ? 1 : int'(cfg_model.ramp_step);
      if (pos == target) return 1'b0;
      if (pos < target) pos = (target - pos <= st) ? target : pos + st;
      else pos = (pos - target <= st) ? target : pos - st;
      return 1'b1;
   endfunction

   // One tick: a phase already at its target is passed without using the tick.
   function automatic void advance_gripper();
      int target;
      bit moved;
      for (int round = 0; round < 6 && grip_phase != rcss_pkg::PH_IDLE; round++) begin
         case (grip_phase)
            rcss_pkg::PH_LOWER: begin
               moved = step_servo(lift_pos, int'(cfg_model.lift_low_angle));
               if (lift_pos == cfg_model.lift_low_angle) grip_phase = rcss_pkg::PH_GRIP;
               if (moved) return;
            end
            rcss_pkg::PH_GRIP: begin
               target = (grip_op == rcss_pkg::OP_PICKUP) ? int'(cfg_model.grip_closed_angle)
                                                         : int'(cfg_model.grip_open_angle);
               moved = step_servo(grip_pos, target);
               if (grip_pos == target) begin
                  if (grip_op == rcss_pkg::OP_PICKUP) begin
                     grip_phase = rcss_pkg::PH_SETTLE;
                     settle_cnt = 0;
                  end else begin
                     grip_phase = rcss_pkg::PH_RAISE;
                  end
               end
               if (moved) return;
            end
            rcss_pkg::PH_SETTLE: begin
               if (settle_cnt < cfg_model.settle_ticks) begin
                  settle_cnt = (settle_cnt + 1) & 15;
                  if (settle_cnt >= cfg_model.settle_ticks) grip_phase = rcss_pkg::PH_RAISE;
                  return;
               end
               grip_phase = rcss_pkg::PH_RAISE;
            end
            rcss_pkg::PH_RAISE: begin
               moved = step_servo(lift_pos, int'(cfg_model.lift_high_angle));
               if (lift_pos == cfg_model.lift_high_angle) begin
                  grip_phase = rcss_pkg::PH_IDLE;
                  grip_op = rcss_pkg::OP_NONE;
               end
               if (moved) return;
            end
            default: begin
               grip_phase = rcss_pkg::PH_IDLE;
               grip_op = rcss_pkg::OP_NONE;
            end
         endcase
      end
   endfunction

   function automatic logic [rcss_pkg::PulseWidth-1:0] wheel_pulse(logic signed [7:0] spd,
                                                                   bit plus);
      int s;
      int p;
      s = spd;
      if (s == 0) return '0;
      p = int'(cfg_model.neutral_pulse_us) + (plus ? 2 * s : -2 * s);
      if (p < 0) p = 0;
      if (p > 4095) p = 4095;
      return rcss_pkg::PulseWidth'(p);
   endfunction

   function automatic servo_report_type servo_predict(logic kind, logic [7:0] b);
      servo_report_type rep;
      int mag;
      logic [7:0] spd;
      if (kind == rcss_pkg::ITEM_TICK) begin
         advance_gripper();
      end else if (b == rcss_pkg::CmdStop) begin
         wheel_left = '0;
         wheel_right = '0;
      end else if (b == rcss_pkg::CmdPickup || b == rcss_pkg::CmdDrop) begin
         if (grip_phase == rcss_pkg::PH_IDLE) begin
            grip_op = (b == rcss_pkg::CmdPickup) ? rcss_pkg::OP_PICKUP : rcss_pkg::OP_DROP;
            grip_phase = rcss_pkg::PH_LOWER;
            settle_cnt = 0;
         end
      end else if (b != rcss_pkg::CmdNone) begin
         mag = 2 * (b >> 2);
         spd = b[1] ? 8'(mag) : 8'(256 - mag);
         if (b[0]) wheel_right = spd;
         else wheel_left = spd;
      end
      rep.left_pulse = wheel_pulse(wheel_left, 1'b1);
      rep.right_pulse = wheel_pulse(wheel_right, 1'b0);
      rep.lift = rcss_pkg::AngleWidth'(lift_pos);
      rep.grip = rcss_pkg::AngleWidth'(grip_pos);
      rep.busy = (grip_phase != rcss_pkg::PH_IDLE);
      return rep;
   endfunction

   task automatic report_mismatch(string msg);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   task automatic queue_cmd(logic kind, logic [7:0] rx);
      servo_cmd_type c;
      c.kind = kind;
      c.rx = rx;
      pending_cmds.push_back(c);
   endtask

   // Mostly complete pickup and drop sequences with speed bytes mixed in,
   // the rest stray bytes and loose ticks. A sequence that would run past
   // the item count is cut short.
   task automatic queue_random(int n, int seq_ticks);
      int pushed;
      int choice;
      pushed = 0;
      while (pushed < n) begin
         choice = $urandom_range(0, 9);
         if (choice <= 5) begin
            queue_cmd(rcss_pkg::ITEM_BYTE, $urandom_range(0, 1) ? rcss_pkg::CmdPickup
                                                                : rcss_pkg::CmdDrop);
            pushed++;
            repeat (seq_ticks + $urandom_range(0, 4)) begin
               if (pushed < n) begin
                  if ($urandom_range(0, 7) == 0) begin
                     queue_cmd(rcss_pkg::ITEM_BYTE, 8'($urandom_range(1, 252)));
                     pushed++;
                  end
                  queue_cmd(rcss_pkg::ITEM_TICK, 8'($urandom));
                  pushed++;
               end
            end
         end else if (choice <= 7) begin
            queue_cmd(rcss_pkg::ITEM_BYTE, $urandom_range(0, 5) == 0
                                           ? rcss_pkg::CmdStop
                                           : 8'($urandom_range(1, 252)));
            pushed++;
         end else if (choice == 8) begin
            queue_cmd(rcss_pkg::ITEM_BYTE, 8'($urandom));
            pushed++;
         end else begin
            repeat ($urandom_range(1, 5)) begin
               queue_cmd(rcss_pkg::ITEM_TICK, 8'($urandom));
               pushed++;
            end
         end
      end
   endtask

   task automatic write_reg(logic [rcss_pkg::CsrIdxWidth-1:0] idx, int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= rcss_pkg::CsrDatWidth'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         rcss_pkg::REG_RAMP_STEP:
            cfg_model.ramp_step = rcss_pkg::StepWidth'(value);
         rcss_pkg::REG_LIFT_LOW:
            cfg_model.lift_low_angle = rcss_pkg::AngleWidth'(value);
         rcss_pkg::REG_LIFT_HIGH:
            cfg_model.lift_high_angle = rcss_pkg::AngleWidth'(value);
         rcss_pkg::REG_GRIP_OPEN:
            cfg_model.grip_open_angle = rcss_pkg::AngleWidth'(value);
         rcss_pkg::REG_GRIP_CLOSED:
            cfg_model.grip_closed_angle = rcss_pkg::AngleWidth'(value);
         rcss_pkg::REG_NEUTRAL:
            cfg_model.neutral_pulse_us = rcss_pkg::AngleWidth'(value);
         rcss_pkg::REG_SETTLE_TICKS:
            cfg_model.settle_ticks = rcss_pkg::SettleWidth'(value);
         default: ;
      endcase
   endtask

   // Targets a few steps from where the servos now stand, so that slow ramps
   // still finish their sequences quickly.
   task automatic write_near_targets();
      int closed;
      write_reg(rcss_pkg::REG_LIFT_HIGH, lift_pos);
      write_reg(rcss_pkg::REG_LIFT_LOW, (lift_pos >= 3) ? lift_pos - 3 : lift_pos + 3);
      closed = (grip_pos >= 4) ? grip_pos - 4 : grip_pos;
      write_reg(rcss_pkg::REG_GRIP_CLOSED, closed);
      write_reg(rcss_pkg::REG_GRIP_OPEN, closed + 4);
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_valid || expected_reports.size() != 0)
         @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   always @(posedge clock) begin : cmd_driver
      servo_cmd_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_reports.push_back(servo_predict(req_item_kind, req_rx_byte));
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
               if (idle_on && $urandom_range(0, 7) == 0) begin
                  send_gap = $urandom_range(0, 2);
                  req_valid <= 1'b0;
               end else begin
                  nxt = pending_cmds.pop_front();
                  req_valid <= 1'b1;
                  req_item_kind <= nxt.kind;
                  req_rx_byte <= nxt.rx;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      servo_report_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               report_mismatch("result transaction with nothing expected");
            end else begin
               want = expected_reports.pop_front();
               if (rsp_left_pulse_us !== want.left_pulse)
                  report_mismatch($sformatf("left_pulse_us got %0d expected %0d",
                                            rsp_left_pulse_us, want.left_pulse));
               if (rsp_right_pulse_us !== want.right_pulse)
                  report_mismatch($sformatf("right_pulse_us got %0d expected %0d",
                                            rsp_right_pulse_us, want.right_pulse));
               if (rsp_lift_angle !== want.lift)
                  report_mismatch($sformatf("lift_angle got %0d expected %0d",
                                            rsp_lift_angle, want.lift));
               if (rsp_grip_angle !== want.grip)
                  report_mismatch($sformatf("grip_angle got %0d expected %0d",
                                            rsp_grip_angle, want.grip));
               if (rsp_gripper_busy !== want.busy)
                  report_mismatch($sformatf("gripper_busy got %0b expected %0b",
                                            rsp_gripper_busy, want.busy));
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_stall_req) begin
            rsp_stall_req = 1'b0;
            hold_left = LongStall - 1;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      cfg_model.ramp_step = rcss_pkg::RampStepRst;
      cfg_model.lift_low_angle = rcss_pkg::LiftLowRst;
      cfg_model.lift_high_angle = rcss_pkg::LiftHighRst;
      cfg_model.grip_open_angle = rcss_pkg::GripOpenRst;
      cfg_model.grip_closed_angle = rcss_pkg::GripClosedRst;
      cfg_model.neutral_pulse_us = rcss_pkg::NeutralRst;
      cfg_model.settle_ticks = rcss_pkg::SettleRst;
      wheel_left = '0;
      wheel_right = '0;
      grip_op = rcss_pkg::OP_NONE;
      grip_phase = rcss_pkg::PH_IDLE;
      lift_pos = rcss_pkg::LiftPosRst;
      grip_pos = rcss_pkg::GripPosRst;
      settle_cnt = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: byte decode extremes, stop, ignored bytes, and start
      // commands arriving while a sequence is already running.
      queue_cmd(rcss_pkg::ITEM_BYTE, rcss_pkg::CmdStop);
      queue_cmd(rcss_pkg::ITEM_BYTE, rcss_pkg::CmdNone);
      queue_cmd(rcss_pkg::ITEM_BYTE, 8'd1);
      queue_cmd(rcss_pkg::ITEM_BYTE, 8'd2);
      queue_cmd(rcss_pkg::ITEM_BYTE, 8'd3);
      queue_cmd(rcss_pkg::ITEM_BYTE, 8'd4);
      queue_cmd(rcss_pkg::ITEM_BYTE, 8'd251);
      queue_cmd(rcss_pkg::ITEM_BYTE, 8'd252);
      queue_cmd(rcss_pkg::ITEM_BYTE, 8'd250);
      queue_cmd(rcss_pkg::ITEM_BYTE, 8'd249);
      queue_cmd(rcss_pkg::ITEM_TICK, 8'hFF);
      queue_cmd(rcss_pkg::ITEM_BYTE, rcss_pkg::CmdStop);
      queue_cmd(rcss_pkg::ITEM_TICK, 8'h00);
      queue_cmd(rcss_pkg::ITEM_BYTE, rcss_pkg::CmdPickup);
      queue_cmd(rcss_pkg::ITEM_BYTE, rcss_pkg::CmdDrop);
      queue_cmd(rcss_pkg::ITEM_BYTE, rcss_pkg::CmdPickup);
      repeat (4) queue_cmd(rcss_pkg::ITEM_TICK, 8'h55);
      queue_cmd(rcss_pkg::ITEM_BYTE, 8'hAA);
      queue_cmd(rcss_pkg::ITEM_BYTE, 8'h55);
      queue_cmd(rcss_pkg::ITEM_BYTE, rcss_pkg::CmdStop);
      queue_random(260, 215);
      wait_drained();

      // Fast ramps across a wide angle range (0 to 1800), longest settle, high neutral.
      write_reg(rcss_pkg::REG_RAMP_STEP, 100);
      write_reg(rcss_pkg::REG_LIFT_LOW, 0);
      write_reg(rcss_pkg::REG_LIFT_HIGH, 1800);
      write_reg(rcss_pkg::REG_GRIP_OPEN, 1800);
      write_reg(rcss_pkg::REG_GRIP_CLOSED, 0);
      write_reg(rcss_pkg::REG_NEUTRAL, 2000);
      write_reg(rcss_pkg::REG_SETTLE_TICKS, 15);
      queue_random(300, 70);
      // The result side holds off while items keep coming, filling the block.
      rsp_stall_req = 1'b1;
      wait_drained();

      // Single-step ramps over short distances, no settle, low neutral.
      write_reg(rcss_pkg::REG_RAMP_STEP, 1);
      write_reg(rcss_pkg::REG_SETTLE_TICKS, 0);
      write_reg(rcss_pkg::REG_NEUTRAL, 1000);
      write_near_targets();
      queue_random(200, 12);
      wait_drained();

      // Mid-range steps that would overshoot their targets and land on them; the sender pauses
      // halfway until every result is back.
      write_reg(rcss_pkg::REG_RAMP_STEP, 37);
      write_reg(rcss_pkg::REG_LIFT_LOW, 600);
      write_reg(rcss_pkg::REG_LIFT_HIGH, 1500);
      write_reg(rcss_pkg::REG_GRIP_OPEN, 1200);
      write_reg(rcss_pkg::REG_GRIP_CLOSED, 300);
      write_reg(rcss_pkg::REG_NEUTRAL, 1750);
      write_reg(rcss_pkg::REG_SETTLE_TICKS, 7);
      queue_random(150, 80);
      wait_drained();
      queue_random(150, 80);
      wait_drained();

      // A zero ramp step behaves as one; a low neutral drives reverse pulses
      // to zero; a write to the unmapped index must change nothing.
      write_reg(rcss_pkg::REG_RAMP_STEP, 0);
      write_reg(rcss_pkg::REG_NEUTRAL, 100);
      write_reg(rcss_pkg::REG_SETTLE_TICKS, 2);
      write_reg(RegUnmapped, 11'h7FF);
      write_near_targets();
      queue_random(150, 14);
      wait_drained();

      // Largest step with the lift and grip ends swapped, no idling.
      idle_on = 1'b0;
      write_reg(rcss_pkg::REG_RAMP_STEP, 127);
      write_reg(rcss_pkg::REG_LIFT_LOW, 1800);
      write_reg(rcss_pkg::REG_LIFT_HIGH, 0);
      write_reg(rcss_pkg::REG_GRIP_OPEN, 0);
      write_reg(rcss_pkg::REG_GRIP_CLOSED, 1800);
      write_reg(rcss_pkg::REG_NEUTRAL, 1500);
      write_reg(rcss_pkg::REG_SETTLE_TICKS, 5);
      queue_random(200, 50);
      wait_drained();

      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
